// ===== rtl/core/cba_pkg.sv =====
// Shared types and constants for the compacting bump allocator.
`default_nettype none
package cba_pkg;

    localparam int MAX_BLOCKS   = 32;
    localparam int HEADER_BYTES = 32;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int LIVE_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [26:0] HDR27       = 27'(HEADER_BYTES);
    localparam logic [24:0] POOL_RESET  = 25'd65536;

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_FREE_ALL = 2'd2;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEMORY = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [15:0] handle;
        logic [24:0] offset;
        logic [24:0] size;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_entry;
        logic             shift_en;
        logic [IDX_W-1:0] shift_idx;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] handle;
        logic [24:0] request_bytes;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_relocation;
        logic [15:0] block_handle;
        logic [24:0] data_offset;
        logic [24:0] used_bytes;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/cba_cell.sv =====
// One table slot: holds an entry, takes its upper neighbor's entry on a shift at or above the shift index.
`default_nettype none
module cba_cell (
    input  wire logic                    clk,
    input  wire logic [cba_pkg::IDX_W-1:0] cell_idx,
    input  wire cba_pkg::cell_ctl_t      ctl,
    input  wire cba_pkg::entry_t         shift_in,
    output cba_pkg::entry_t              entry
);
    import cba_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_en && (cell_idx >= ctl.shift_idx))
        begin
            entry_next = shift_in;
        end
        else if (ctl.wr_en && (cell_idx == ctl.wr_idx))
        begin
            entry_next = ctl.wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// ===== rtl/core/compacting_bump_allocator.sv =====
// Top level: sequencer walking a chain of table cells.
// Allocate without compaction, free-all, unused ops: final beat in the cycle after start.
// Free: FIND walks the entries up to the match, SHIFT closes the gap, then HOLES rescans
//   every remaining entry for holes; an unknown handle ends once FIND passes all live entries.
// Compaction: COMPACT walks every live entry, one relocation beat per moved block, then RETRY repeats the allocation.
// busy drops as the final beat shows; results cannot be stalled; reset: empty, pool 65536.
`default_nettype none
module compacting_bump_allocator (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cba_pkg::item_t   item,
    output logic                  result_valid,
    output cba_pkg::result_t      result,
    input  wire logic             cfg_we,
    input  wire logic [24:0]      cfg_wdata
);
    import cba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_HOLES,
        S_COMPACT,
        S_RETRY
    } state_t;

    state_t              state_reg;
    logic [24:0]         pool_reg;
    logic [LIVE_W-1:0]   live_reg;
    logic [24:0]         next_free_reg;
    logic                holes_reg;
    logic [24:0]         payload_reg;
    logic [LIVE_W-1:0]   k_reg;
    logic [25:0]         cursor_reg;
    logic [IDX_W-1:0]    found_reg;
    logic [15:0]         handle_reg;
    logic [24:0]         size_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    entry_t              cell_q [MAX_BLOCKS];
    cell_ctl_t           ctl;
    entry_t              rd;
    logic [24:0]         fit_size;
    logic [15:0]         cur_handle;
    logic                fit;
    logic [24:0]         alloc_off;
    logic [24:0]         dest;
    logic                at_end;
    logic                table_full;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++)
        begin : g_cell
            if (gi == MAX_BLOCKS - 1)
            begin : g_top
                cba_cell u_cell (
                    .clk      (clk),
                    .cell_idx (IDX_W'(gi)),
                    .ctl      (ctl),
                    .shift_in (cell_q[gi]),
                    .entry    (cell_q[gi])
                );
            end
            else
            begin : g_mid
                cba_cell u_cell (
                    .clk      (clk),
                    .cell_idx (IDX_W'(gi)),
                    .ctl      (ctl),
                    .shift_in (cell_q[gi+1]),
                    .entry    (cell_q[gi])
                );
            end
        end
    endgenerate

    assign rd         = cell_q[k_reg[IDX_W-1:0]];
    assign at_end     = (k_reg == live_reg);
    assign table_full = (live_reg >= LIVE_W'(MAX_BLOCKS));
    assign fit_size   = (state_reg == S_IDLE) ? item.request_bytes : size_reg;
    assign cur_handle = (state_reg == S_IDLE) ? item.handle : handle_reg;
    assign fit        = ({2'b00, next_free_reg} + HDR27 + {2'b00, fit_size})
                        <= {2'b00, pool_reg};
    assign alloc_off  = 25'({2'b00, next_free_reg} + HDR27);
    assign dest       = 25'({1'b0, cursor_reg} + HDR27);

    always_comb
    begin
        ctl           = '0;
        ctl.shift_idx = found_reg;
        ctl.wr_idx    = live_reg[IDX_W-1:0];
        ctl.wr_entry  = '{handle: cur_handle, offset: alloc_off, size: fit_size};
        case (state_reg)
            S_IDLE:
            begin
                ctl.wr_en = start && (item.operation == OP_ALLOC) && !table_full && fit;
            end
            S_RETRY:
            begin
                ctl.wr_en = fit;
            end
            S_SHIFT:
            begin
                ctl.shift_en = 1'b1;
            end
            S_COMPACT:
            begin
                ctl.wr_idx   = k_reg[IDX_W-1:0];
                ctl.wr_entry = '{handle: rd.handle, offset: dest, size: rd.size};
                ctl.wr_en    = !at_end && (dest != rd.offset);
            end
            default:
            begin
                ctl.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pool_reg         <= POOL_RESET;
            live_reg         <= '0;
            next_free_reg    <= '0;
            holes_reg        <= 1'b0;
            payload_reg      <= '0;
            k_reg            <= '0;
            cursor_reg       <= '0;
            found_reg        <= '0;
            handle_reg       <= '0;
            size_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                pool_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        handle_reg <= item.handle;
                        size_reg   <= item.request_bytes;
                        k_reg      <= '0;
                        cursor_reg <= '0;
                        case (item.operation)
                            OP_ALLOC:
                            begin
                                if (table_full)
                                begin
                                    result_valid_reg <= 1'b1;
                                    result_reg <= '{ST_FULL, 1'b0, item.handle, 25'd0,
                                                    payload_reg, 1'b1};
                                end
                                else if (fit)
                                begin
                                    live_reg         <= live_reg + 1'b1;
                                    next_free_reg    <= alloc_off + fit_size;
                                    payload_reg      <= payload_reg + fit_size;
                                    result_valid_reg <= 1'b1;
                                    result_reg <= '{ST_OK, 1'b0, item.handle, alloc_off,
                                                    payload_reg + fit_size, 1'b1};
                                end
                                else if (holes_reg)
                                begin
                                    state_reg <= S_COMPACT;
                                end
                                else
                                begin
                                    result_valid_reg <= 1'b1;
                                    result_reg <= '{ST_NO_MEMORY, 1'b0, item.handle, 25'd0,
                                                    payload_reg, 1'b1};
                                end
                            end
                            OP_FREE:
                            begin
                                state_reg <= S_FIND;
                            end
                            OP_FREE_ALL:
                            begin
                                live_reg         <= '0;
                                next_free_reg    <= '0;
                                holes_reg        <= 1'b0;
                                payload_reg      <= '0;
                                result_valid_reg <= 1'b1;
                                result_reg <= '{ST_OK, 1'b0, 16'd0, 25'd0, 25'd0, 1'b1};
                            end
                            default:
                            begin
                                result_valid_reg <= 1'b1;
                                result_reg <= '{ST_OK, 1'b0, item.handle, 25'd0,
                                                payload_reg, 1'b1};
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (at_end)
                    begin
                        state_reg        <= S_IDLE;
                        result_valid_reg <= 1'b1;
                        result_reg <= '{ST_NOT_ALLOC, 1'b0, handle_reg, 25'd0,
                                        payload_reg, 1'b1};
                    end
                    else if (rd.handle == handle_reg)
                    begin
                        payload_reg <= payload_reg - rd.size;
                        found_reg   <= k_reg[IDX_W-1:0];
                        state_reg   <= S_SHIFT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_SHIFT:
                begin
                    live_reg   <= live_reg - 1'b1;
                    k_reg      <= '0;
                    cursor_reg <= '0;
                    holes_reg  <= 1'b0;
                    state_reg  <= S_HOLES;
                end
                S_HOLES:
                begin
                    if (at_end)
                    begin
                        // cursor ends at the end of the highest block, or 0 when empty
                        next_free_reg    <= cursor_reg[24:0];
                        state_reg        <= S_IDLE;
                        result_valid_reg <= 1'b1;
                        result_reg <= '{ST_OK, 1'b0, handle_reg, 25'd0, payload_reg, 1'b1};
                    end
                    else
                    begin
                        if (({1'b0, cursor_reg} + HDR27) != {2'b00, rd.offset})
                        begin
                            holes_reg <= 1'b1;
                        end
                        cursor_reg <= {1'b0, rd.offset} + {1'b0, rd.size};
                        k_reg      <= k_reg + 1'b1;
                    end
                end
                S_COMPACT:
                begin
                    if (at_end)
                    begin
                        next_free_reg <= cursor_reg[24:0];
                        holes_reg     <= 1'b0;
                        state_reg     <= S_RETRY;
                    end
                    else
                    begin
                        if (dest != rd.offset)
                        begin
                            result_valid_reg <= 1'b1;
                            result_reg <= '{ST_OK, 1'b1, rd.handle, dest, payload_reg, 1'b0};
                        end
                        cursor_reg <= {1'b0, dest} + {1'b0, rd.size};
                        k_reg      <= k_reg + 1'b1;
                    end
                end
                S_RETRY:
                begin
                    state_reg        <= S_IDLE;
                    result_valid_reg <= 1'b1;
                    if (fit)
                    begin
                        live_reg      <= live_reg + 1'b1;
                        next_free_reg <= alloc_off + fit_size;
                        payload_reg   <= payload_reg + fit_size;
                        result_reg <= '{ST_OK, 1'b0, handle_reg, alloc_off,
                                        payload_reg + fit_size, 1'b1};
                    end
                    else
                    begin
                        result_reg <= '{ST_NO_MEMORY, 1'b0, handle_reg, 25'd0,
                                        payload_reg, 1'b1};
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ===== rtl/core/cba_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
`default_nettype none
module cba_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic             result_valid,
    input  wire cba_pkg::result_t result
);
    import cba_pkg::*;

    // every accepted command produces either more work or its final beat
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || result_valid)
        else $error("accepted command produced nothing");

    a_reloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_relocation |-> busy)
        else $error("relocation beat outside a compaction");

    a_reloc_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_relocation |-> !result.last && result.status == ST_OK)
        else $error("relocation beat marked last or failing");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !busy |-> result.last)
        else $error("non-final beat while idle");

endmodule

bind compacting_bump_allocator cba_checker u_cba_checker (.*);
`default_nettype wire
